>>> rtl/gbb_pkg.sv
// Shared types and constants of the glyph bitmap blitter.
package gbb_pkg;

  localparam int MAX_FRAME_WIDTH_DEF = 1024;
  localparam int LANES = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [10:0] FRAME_WIDTH_RESET = 11'd320;
  localparam logic [7:0] FRAME_HEIGHT_RESET = 8'd240;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One bitmap byte after clipping: a visible mask and the point of every lane.
  typedef struct packed {
    logic [LANES-1:0]       mask;
    logic [LANES-1:0][10:0] xs;
    logic [LANES-1:0][7:0]  ys;
    logic [15:0]            color;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

>>> rtl/gbb_ifs.sv
// Channel interfaces of the glyph bitmap blitter.
interface gbb_glyph_if;
  logic               valid;
  logic               ready;
  gbb_pkg::op_t       op;
  logic [7:0]         glyph_width;
  logic [7:0]         glyph_height;
  logic signed [7:0]  offset_x;
  logic signed [7:0]  offset_y;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [15:0]        ink_color;
  logic [7:0]         bitmap_byte;

  modport source (output valid, op, glyph_width, glyph_height, offset_x, offset_y,
                  origin_x, origin_y, ink_color, bitmap_byte, input ready);
  modport sink (input valid, op, glyph_width, glyph_height, offset_x, offset_y,
                origin_x, origin_y, ink_color, bitmap_byte, output ready);
endinterface

interface gbb_pixel_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [17:0] pixel_address;
  logic [15:0] pixel_color;
  logic        last;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                output ready);
  modport mon (input valid, ready, pixel_x, pixel_y, pixel_address, pixel_color, last);
endinterface

interface gbb_cfg_if;
  logic              valid;
  logic              ready;
  gbb_pkg::cfg_reg_t index;
  logic [10:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport mon (input valid, ready, index, data);
endinterface

>>> rtl/glyph_bitmap_blitter_top.sv
// Top level of the glyph bitmap blitter.
// The glyph channel takes start requests (metrics, origin, colour) and
// bitmap-byte requests, eight glyph bits each, most significant first.
// The write channel carries one framebuffer pixel write per request, with
// last set on the final write that a bitmap byte causes.
// The cfg channel sets frame width and height; it is always ready.
// A request is accepted whenever the two-entry queue has room.
// A byte moves from the queue to the current-byte register, whose
// writes are registered onto the write port, one pixel per cycle while the
// receiver is ready, one write per visible pixel, at most eight; bytes with
// no visible pixel and start requests use only the front end.
// Reset clears the glyph state, selects a 320 by 240 frame and empties
// the queue. When the receiver stalls, the pending write holds, the queue
// fills and the glyph channel drops ready.
module glyph_bitmap_blitter_top #(
  parameter int MAX_FRAME_WIDTH = gbb_pkg::MAX_FRAME_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  gbb_glyph_if.sink   glyph,
  gbb_pixel_if.source write,
  gbb_cfg_if.sink     cfg
);
  import gbb_pkg::*;

  entry_t        entry;
  entry_t        head;
  queue_status_t qstat;
  logic          push;
  logic          pop;
  logic [10:0]   fw;

  gbb_front #(.MAX_FRAME_WIDTH(MAX_FRAME_WIDTH)) u_front (
    .clk   (clk),
    .rst   (rst),
    .glyph (glyph),
    .cfg   (cfg),
    .qstat (qstat),
    .push  (push),
    .entry (entry),
    .fw    (fw)
  );

  gbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  gbb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .fw    (fw),
    .write (write)
  );

endmodule

>>> rtl/gbb_front.sv
// Front end: configuration registers, glyph state and per-byte lane clipping.
module gbb_front #(
  parameter int MAX_FRAME_WIDTH = gbb_pkg::MAX_FRAME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  gbb_glyph_if.sink        glyph,
  gbb_cfg_if.sink          cfg,
  input  gbb_pkg::queue_status_t qstat,
  output logic             push,
  output gbb_pkg::entry_t  entry,
  output logic [10:0]      fw
);
  import gbb_pkg::*;

  logic [10:0] frame_width;
  logic [7:0]  frame_height;
  logic [7:0]  column_pos, column_pos_next;
  logic [7:0]  row_pos, row_pos_next;
  logic [7:0]  active_width;
  logic [7:0]  active_height;
  logic [16:0] base_x;
  logic [16:0] base_y;
  logic [15:0] active_color;
  logic        accept;
  logic        active;

  assign cfg.ready   = 1'b1;
  assign glyph.ready = !qstat.full;
  assign accept      = glyph.valid && !qstat.full;
  assign active      = (active_width != 8'd0) && (active_height != 8'd0);

  always_comb begin
    if (32'(frame_width) > MAX_FRAME_WIDTH) begin
      fw = 11'(MAX_FRAME_WIDTH);
    end else begin
      fw = frame_width;
    end
  end

  always_comb begin
    logic [7:0]  c;
    logic [7:0]  r;
    logic [17:0] lane_x;
    logic [17:0] lane_y;
    c = column_pos;
    r = row_pos;
    entry.mask  = '0;
    entry.color = active_color;
    for (int b = 0; b < LANES; b++) begin
      lane_x = {base_x[16], base_x} + {10'd0, c};
      lane_y = {base_y[16], base_y} + {10'd0, r};
      entry.xs[b] = lane_x[10:0];
      entry.ys[b] = lane_y[7:0];
      if (active && (r < active_height)) begin
        if (glyph.bitmap_byte[LANES-1-b] && !lane_x[17] && !lane_y[17] &&
            (lane_x < {7'd0, fw}) && (lane_y < {10'd0, frame_height})) begin
          entry.mask[b] = 1'b1;
        end
        c = c + 8'd1;
        if (c >= active_width) begin
          c = 8'd0;
          r = r + 8'd1;
        end
      end
    end
    column_pos_next = c;
    row_pos_next    = r;
  end

  assign push = accept && (glyph.op == OP_BYTE) && (entry.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.data[7:0];
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos    <= '0;
      row_pos       <= '0;
      active_width  <= '0;
      active_height <= '0;
      base_x        <= '0;
      base_y        <= '0;
      active_color  <= '0;
    end else if (accept) begin
      unique case (glyph.op)
        OP_START: begin
          active_width  <= glyph.glyph_width;
          active_height <= glyph.glyph_height;
          base_x        <= {glyph.origin_x[15], glyph.origin_x} +
                           {{9{glyph.offset_x[7]}}, glyph.offset_x};
          base_y        <= {glyph.origin_y[15], glyph.origin_y} +
                           {{9{glyph.offset_y[7]}}, glyph.offset_y};
          active_color  <= glyph.ink_color;
          column_pos    <= '0;
          row_pos       <= '0;
        end
        OP_BYTE: begin
          column_pos <= column_pos_next;
          row_pos    <= row_pos_next;
        end
        default: begin
          column_pos <= column_pos;
        end
      endcase
    end
  end

endmodule

>>> rtl/gbb_queue.sv
// Short queue of clipped bitmap bytes between front and back end.
module gbb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gbb_pkg::entry_t        wr_entry,
  input  logic                   pop,
  output gbb_pkg::entry_t        head,
  output gbb_pkg::queue_status_t qstat
);
  import gbb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CW'(QUEUE_DEPTH));
  assign head        = mem[rptr];
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/gbb_back.sv
// Back end: issues one pixel write per cycle while the receiver is ready, from the visible lanes of a byte.
module gbb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  gbb_pkg::entry_t        head,
  input  gbb_pkg::queue_status_t qstat,
  output logic                   pop,
  input  logic [10:0]            fw,
  gbb_pixel_if.source            write
);
  import gbb_pkg::*;

  entry_t            cur;
  logic [2:0]        sel;
  logic [LANES-1:0]  rem;
  logic              adv;
  logic              emit;
  logic [19:0]       addr;

  always_comb begin
    sel = '0;
    for (int b = LANES - 1; b >= 0; b--) begin
      if (cur.mask[b]) begin
        sel = 3'(b);
      end
    end
  end

  assign adv  = !write.valid || write.ready;
  assign emit = adv && (cur.mask != '0);

  always_comb begin
    rem = cur.mask;
    if (emit) begin
      rem[sel] = 1'b0;
    end
  end

  assign pop  = !qstat.empty && (rem == '0);
  assign addr = 20'(cur.ys[sel]) * 20'(fw) + 20'(cur.xs[sel]);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur.xs    <= head.xs;
      cur.ys    <= head.ys;
      cur.color <= head.color;
    end
    if (emit) begin
      write.pixel_x       <= cur.xs[sel][9:0];
      write.pixel_y       <= cur.ys[sel];
      write.pixel_address <= addr[17:0];
      write.pixel_color   <= cur.color;
      write.last          <= (rem == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mask    <= '0;
      write.valid <= 1'b0;
    end else begin
      cur.mask <= pop ? head.mask : rem;
      if (adv) begin
        write.valid <= (cur.mask != '0);
      end
    end
  end

endmodule

>>> rtl/gbb_checker.sv
// Port-level assertions of the glyph bitmap blitter and their binding.
module gbb_checker #(
  parameter int MAX_FRAME_WIDTH = gbb_pkg::MAX_FRAME_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  gbb_pixel_if.source write,
  gbb_cfg_if.sink     cfg
);
  import gbb_pkg::*;

  logic [10:0] mon_width;
  logic [7:0]  mon_height;
  logic [10:0] mon_fw;
  logic [17:0] row_start;
  logic [17:0] col_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      mon_width  <= FRAME_WIDTH_RESET;
      mon_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_FRAME_WIDTH) begin
        mon_width <= cfg.data;
      end else begin
        mon_height <= cfg.data[7:0];
      end
    end
  end

  assign mon_fw    = (32'(mon_width) > MAX_FRAME_WIDTH) ? 11'(MAX_FRAME_WIDTH) : mon_width;
  assign row_start = 18'(19'(write.pixel_y) * 19'(mon_fw));
  assign col_part  = write.pixel_address - row_start;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !write.valid)
    else $error("write valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    write.valid && !write.ready |=> write.valid && $stable(write.pixel_address) &&
      $stable(write.last))
    else $error("stalled write request changed");

  a_inside_frame: assert property (@(posedge clk) disable iff (rst)
    write.valid |-> (write.pixel_y < mon_height) && ({1'b0, write.pixel_x} < mon_fw))
    else $error("write outside the frame");

  a_address: assert property (@(posedge clk) disable iff (rst)
    write.valid |-> col_part[9:0] == write.pixel_x)
    else $error("pixel address does not match row and column");

endmodule

bind glyph_bitmap_blitter_top gbb_checker #(.MAX_FRAME_WIDTH(MAX_FRAME_WIDTH)) u_checker (
  .clk   (clk),
  .rst   (rst),
  .write (write),
  .cfg   (cfg)
);

>>> tb/sv/tb_glyph_bitmap_blitter_top.sv
// Self-checking testbench for the glyph bitmap blitter: glyph requests in, pixel writes scored.
module tb_glyph_bitmap_blitter_top;
  import gbb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_SLACK  = 16;
  localparam int IDLE_PERCENT = 27;
  localparam int MAX_WIDTH    = MAX_FRAME_WIDTH_DEF;

  typedef struct {
    op_t               op;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]       ink_color;
    logic [7:0]        bitmap_byte;
  } glyph_req_t;

  typedef struct {
    logic [9:0]  x;
    logic [7:0]  y;
    logic [17:0] address;
    logic [15:0] color;
    logic        last;
  } pixel_write_t;

  class glyph_scoreboard;
    logic [10:0]        frame_width;
    logic [7:0]         frame_height;
    logic [7:0]         column;
    logic [7:0]         row;
    logic [7:0]         width;
    logic [7:0]         height;
    logic signed [16:0] base_x;
    logic signed [16:0] base_y;
    logic [15:0]        ink;
    pixel_write_t       expected_writes[$];
    int                 failures;
    int                 writes_checked;
    int                 glyphs_started;

    function new();
      frame_width    = FRAME_WIDTH_RESET;
      frame_height   = FRAME_HEIGHT_RESET;
      column         = '0;
      row            = '0;
      width          = '0;
      height         = '0;
      base_x         = '0;
      base_y         = '0;
      ink            = '0;
      failures       = 0;
      writes_checked = 0;
      glyphs_started = 0;
    endfunction

    function void set_register(cfg_reg_t index, logic [10:0] data);
      if (index == REG_FRAME_WIDTH) begin
        frame_width = data;
      end else begin
        frame_height = data[7:0];
      end
    endfunction

    function int clipped_width();
      return (frame_width > MAX_WIDTH) ? MAX_WIDTH : int'(frame_width);
    endfunction

    function void note_request(glyph_req_t r);
      pixel_write_t writes[$];
      pixel_write_t w;
      int           fw;
      int           px;
      int           py;
      if (r.op == OP_START) begin
        width  = r.glyph_width;
        height = r.glyph_height;
        base_x = r.origin_x + r.offset_x;
        base_y = r.origin_y + r.offset_y;
        ink    = r.ink_color;
        column = '0;
        row    = '0;
        glyphs_started++;
        return;
      end
      if (width == 0 || height == 0) begin
        return;
      end
      fw = clipped_width();
      for (int b = 7; b >= 0; b--) begin
        if (row >= height) begin
          break;
        end
        if (r.bitmap_byte[b]) begin
          px = int'(base_x) + int'(column);
          py = int'(base_y) + int'(row);
          if (px >= 0 && py >= 0 && px < fw && py < int'(frame_height)) begin
            w.x       = px[9:0];
            w.y       = py[7:0];
            w.address = 18'(py * fw + px);
            w.color   = ink;
            w.last    = 1'b0;
            writes.push_back(w);
          end
        end
        column = column + 8'd1;
        if (column >= width) begin
          column = '0;
          row    = row + 8'd1;
        end
      end
      if (writes.size() > 0) begin
        writes[writes.size() - 1].last = 1'b1;
      end
      foreach (writes[i]) begin
        expected_writes.push_back(writes[i]);
      end
    endfunction

    function void check_write(pixel_write_t got);
      pixel_write_t want;
      if (expected_writes.size() == 0) begin
        $error("unexpected pixel write: x %0d, y %0d", got.x, got.y);
        failures++;
        return;
      end
      want = expected_writes.pop_front();
      writes_checked++;
      if (got.x !== want.x) begin
        $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
        failures++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
        failures++;
      end
      if (got.address !== want.address) begin
        $error("pixel_address: expected %0d, actual %0d", want.address, got.address);
        failures++;
      end
      if (got.color !== want.color) begin
        $error("pixel_color: expected %h, actual %h", want.color, got.color);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        failures++;
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idling;
  int   cycle_count;
  int   items_sent;
  int   hold_requests;
  int   holds_served;
  int   hold_left;

  glyph_scoreboard sb;

  gbb_glyph_if glyph();
  gbb_pixel_if write();
  gbb_cfg_if   cfg();

  glyph_bitmap_blitter_top dut (
    .clk   (clk),
    .rst   (rst),
    .glyph (glyph),
    .write (write),
    .cfg   (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d writes outstanding.",
               cycle_count, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver counts out its own long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      hold_left    = HOLD_CYCLES;
      holds_served = holds_served + 1;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      write.ready <= 1'b0;
    end else begin
      write.ready <= !rst && (!idling || $urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin : watch_writes
    pixel_write_t seen;
    if (!rst && write.valid && write.ready) begin
      seen.x       = write.pixel_x;
      seen.y       = write.pixel_y;
      seen.address = write.pixel_address;
      seen.color   = write.pixel_color;
      seen.last    = write.last;
      sb.check_write(seen);
    end
  end

  function automatic glyph_req_t make_start(logic [7:0] w, logic [7:0] h,
                                            logic signed [7:0] ox, logic signed [7:0] oy,
                                            logic signed [15:0] gx, logic signed [15:0] gy,
                                            logic [15:0] color);
    glyph_req_t r;
    r.op           = OP_START;
    r.glyph_width  = w;
    r.glyph_height = h;
    r.offset_x     = ox;
    r.offset_y     = oy;
    r.origin_x     = gx;
    r.origin_y     = gy;
    r.ink_color    = color;
    r.bitmap_byte  = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic glyph_req_t make_byte(logic [7:0] bits);
    glyph_req_t r;
    r.op           = OP_BYTE;
    r.glyph_width  = 8'($urandom_range(255));
    r.glyph_height = 8'($urandom_range(255));
    r.offset_x     = 8'($urandom_range(255));
    r.offset_y     = 8'($urandom_range(255));
    r.origin_x     = 16'($urandom_range(65535));
    r.origin_y     = 16'($urandom_range(65535));
    r.ink_color    = 16'($urandom_range(65535));
    r.bitmap_byte  = bits;
    return r;
  endfunction

  function automatic logic [7:0] random_bits();
    int pick;
    pick = $urandom_range(7);
    if (pick < 2) begin
      return 8'hFF;
    end else if (pick == 2) begin
      return 8'h00;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(glyph_req_t r);
    while (idling && $urandom_range(99) < IDLE_PERCENT) begin
      glyph.valid = 1'b0;
      @(negedge clk);
    end
    glyph.valid        = 1'b1;
    glyph.op           = r.op;
    glyph.glyph_width  = r.glyph_width;
    glyph.glyph_height = r.glyph_height;
    glyph.offset_x     = r.offset_x;
    glyph.offset_y     = r.offset_y;
    glyph.origin_x     = r.origin_x;
    glyph.origin_y     = r.origin_y;
    glyph.ink_color    = r.ink_color;
    glyph.bitmap_byte  = r.bitmap_byte;
    @(posedge clk);
    while (!glyph.ready) begin
      @(posedge clk);
    end
    sb.note_request(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    glyph.valid = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_SLACK) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_t index, logic [10:0] data);
    cfg.valid = 1'b1;
    cfg.index = index;
    cfg.data  = data;
    @(posedge clk);
    while (!cfg.ready) begin
      @(posedge clk);
    end
    sb.set_register(index, data);
    @(negedge clk);
  endtask

  task automatic write_config(logic [10:0] fw, logic [7:0] fh);
    write_register(REG_FRAME_WIDTH, fw);
    write_register(REG_FRAME_HEIGHT, {3'b000, fh});
    cfg.valid = 1'b0;
  endtask

  // Mostly well-formed glyphs placed across the frame edges, with some noise
  // starts, truncated bitmaps and bytes running past the end of a glyph.
  task automatic run_glyphs(int count, bit pause_midway);
    int                sent;
    int                kind;
    int                w;
    int                h;
    int                wm;
    int                hm;
    int                nbytes;
    int                fwe;
    int                fhe;
    int                bx;
    int                by;
    logic signed [7:0] ox;
    logic signed [7:0] oy;
    bit                paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < count) begin
      if (pause_midway && !paused && sent >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 8) begin
        send_item(make_start(8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             16'($urandom_range(65535))));
        nbytes = $urandom_range(3);
      end else begin
        if (kind < 14) begin
          w = $urandom_range(16, 255);
          h = 1;
        end else if (kind < 18) begin
          w = $urandom_range(1) ? 0 : $urandom_range(1, 8);
          h = (w == 0) ? $urandom_range(1, 8) : 0;
        end else begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 12);
        end
        wm  = (w == 0) ? 1 : w;
        hm  = (h == 0) ? 1 : h;
        fwe = sb.clipped_width();
        fhe = int'(sb.frame_height);
        if (fwe == 0) begin
          fwe = 16;
        end
        if (fhe == 0) begin
          fhe = 16;
        end
        ox = 8'($urandom_range(255));
        oy = 8'($urandom_range(255));
        bx = int'($urandom_range(fwe + wm - 1)) - wm + 1;
        by = int'($urandom_range(fhe + hm - 1)) - hm + 1;
        send_item(make_start(8'(w), 8'(h), ox, oy, 16'(bx - int'(ox)), 16'(by - int'(oy)),
                             16'($urandom_range(65535))));
        nbytes = (w * h + 7) / 8;
        kind   = $urandom_range(99);
        if (kind < 12 && nbytes > 0) begin
          nbytes = $urandom_range(nbytes - 1);
        end else if (kind < 24) begin
          nbytes = nbytes + $urandom_range(1, 2);
        end
      end
      sent++;
      repeat (nbytes) begin
        send_item(make_byte(random_bits()));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    sb                 = new();
    idling             = 1'b1;
    cycle_count        = 0;
    items_sent         = 0;
    hold_requests      = 0;
    holds_served       = 0;
    hold_left          = 0;
    rst                = 1'b1;
    glyph.valid        = 1'b0;
    glyph.op           = OP_START;
    glyph.glyph_width  = '0;
    glyph.glyph_height = '0;
    glyph.offset_x     = '0;
    glyph.offset_y     = '0;
    glyph.origin_x     = '0;
    glyph.origin_y     = '0;
    glyph.ink_color    = '0;
    glyph.bitmap_byte  = '0;
    write.ready        = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = REG_FRAME_WIDTH;
    cfg.data           = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A byte before any glyph has started must produce nothing.
    send_item(make_byte(8'hFF));
    send_item(make_start(8, 2, 0, 0, 0, 0, 16'hFFFF));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'hA5));
    send_item(make_byte(8'hFF));
    send_item(make_start(3, 3, -6, 2, 5, -3, 16'h0000));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'hFF));
    send_item(make_start(4, 4, 0, 0, 318, 238, 16'h1234));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'hFF));
    send_item(make_start(0, 5, 0, 0, 10, 10, 16'h5555));
    send_item(make_byte(8'hFF));
    send_item(make_start(5, 0, 0, 0, 10, 10, 16'hAAAA));
    send_item(make_byte(8'hFF));
    send_item(make_start(255, 255, 127, -128, -32768, 32767, 16'h8001));
    send_item(make_byte(8'hFF));
    send_item(make_start(255, 255, -128, 127, 32767, -32768, 16'h7FFE));
    send_item(make_byte(8'hFF));
    send_item(make_start(255, 1, 0, 0, 65, 239, 16'hF81F));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'hFF));

    run_glyphs(80, 1'b1);
    wait_drained();
    write_config(11'd2047, 8'd255);
    hold_requests = hold_requests + 1;
    run_glyphs(50, 1'b0);
    wait_drained();
    write_config(11'd1, 8'd1);
    run_glyphs(30, 1'b0);
    wait_drained();
    write_config(11'd0, 8'd20);
    run_glyphs(20, 1'b0);
    wait_drained();
    write_config(11'd40, 8'd0);
    run_glyphs(20, 1'b0);
    wait_drained();
    write_config(11'd1024, 8'd255);
    idling = 1'b0;
    run_glyphs(60, 1'b0);
    idling = 1'b1;
    wait_drained();
    write_config(11'($urandom_range(1, 1024)), 8'($urandom_range(1, 255)));
    run_glyphs(50, 1'b0);
    wait_drained();

    $display("Sent %0d requests over %0d glyphs and checked %0d pixel writes,",
             items_sent, sb.glyphs_started, sb.writes_checked);
    $display("across default, minimal, zero, oversized and random frame sizes.");
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
